>>> hdl/svcu_pkg.sv
// Shared types, constants and the class cost table for the semantic voxel cost block.
`default_nettype none
package svcu_pkg;

  localparam int ADDR_W      = 15;
  localparam int VOXEL_COUNT = 1 << ADDR_W;
  localparam int CLASS_COUNT = 37;
  localparam int ROM_SIZE    = 37;

  localparam logic [12:0] ONE_Q12     = 13'd4096;
  localparam logic [12:0] HALF_Q12    = 13'd2048;
  localparam logic [7:0]  FLOOR_CLASS = 8'd1;

  // floor(x * RECIP10 >> RECIP_SHIFT) == floor(x / 10) for x < 2^18
  localparam logic [15:0] RECIP10     = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    CFG_UNC_WEIGHT   = 2'd0,
    CFG_TALL_LIMIT   = 2'd1,
    CFG_GROUND_CLEAR = 2'd2
  } cfg_reg_t;

  // One word of the voxel store
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  cls;
    logic [12:0] unc;
    logic [12:0] cost;
  } voxel_entry_t;

  localparam logic [12:0] CLASS_COST_ROM [ROM_SIZE] = '{
    13'd4096, 13'd0,    13'd3482, 13'd3277, 13'd2458, 13'd3277, 13'd2867, 13'd3891,
    13'd4096, 13'd3482, 13'd0,    13'd2867, 13'd819,  13'd2867, 13'd3482, 13'd1229,
    13'd3482, 13'd2048, 13'd4096, 13'd410,  13'd1638, 13'd0,    13'd2048, 13'd3686,
    13'd3277, 13'd1229, 13'd1229, 13'd1229, 13'd2048, 13'd3891, 13'd3686, 13'd3277,
    13'd3891, 13'd3891, 13'd2458, 13'd3891, 13'd1638
  };

  // Unknown labels cost one half
  function automatic logic [12:0] class_cost(input logic [7:0] label);
    logic [12:0] res;
    res = HALF_Q12;
    if ((9'(label) < 9'(CLASS_COUNT)) && (9'(label) < 9'(ROM_SIZE))) begin
      res = CLASS_COST_ROM[label[5:0]];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/svcu_voxel_ram.sv
// Single-port-write, registered-read voxel store.
`default_nettype none
module svcu_voxel_ram
  import svcu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire voxel_entry_t      wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output voxel_entry_t           rd_data_r
);

  voxel_entry_t mem_q [VOXEL_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_q[rd_addr];
  end

endmodule
`default_nettype wire

>>> hdl/semantic_voxel_cost_update.sv
// Top level of the semantic voxel cost block: sequencer, arithmetic and stream ports.
`default_nettype none
// Keeps cost, uncertainty, class and a saturating observation count for each of
// 32768 voxels in one on-chip store and answers each observe or query item with
// the voxel's total cost, occupancy and stored fields after any update. After
// reset the store is swept clear, one entry a cycle; in_tready stays low during
// the sweep while configuration writes are still taken. The store read is issued
// at the input transfer itself; the result then passes the registered steps blend
// numerators, divide by ten with write-back, weight product and height scaling,
// and the occupancy step loads the output register. The read-modify-write of the
// single store completes before the next item is taken: in_tready is high only in
// idle, so no new item is accepted until the last has left the occupancy step. A
// finished result waits in the output register while the next item is accepted; a
// second result stalls in the occupancy step until the first has gone.
module semantic_voxel_cost_update
  import svcu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [14:0] voxel_index, [22:15] label, [35:23] uncertainty,
  // [51:36] height, [55:52] zero
  input  wire logic [55:0] in_tdata,
  // [0] func
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [12:0] total_cost, [19:13] occupancy, [32:20] stored_cost,
  // [45:33] stored_uncertainty, [53:46] dominant_class,
  // [69:54] obs_count, [71:70] zero
  output logic [71:0]      out_tdata
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_BLEND  = 7'b0001000,
    S_WEIGHT = 7'b0010000,
    S_SCALE  = 7'b0100000,
    S_OCC    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [12:0]        unc_weight_r;
  logic [14:0]        tall_limit_r;
  logic signed [15:0] ground_clear_r;

  // clearing sweep
  logic [ADDR_W-1:0] clr_addr_r;

  // item registers
  logic               query_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [7:0]         label_r;
  logic [12:0]        obs_unc_r;
  logic signed [15:0] height_r;
  logic [12:0]        sc_r;
  logic [16:0]        num_cost_r, num_unc_r;
  voxel_entry_t       old_r, cur_r;
  logic [13:0]        tsum_r;
  logic [12:0]        total_r;

  // output register
  logic        out_valid_r;
  logic [71:0] out_data_r;

  // store
  voxel_entry_t      rd_data;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  voxel_entry_t      ram_wdata;

  logic in_xfer, out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  svcu_voxel_ram u_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_addr   (in_tdata[ADDR_W-1:0]),
    .rd_data_r (rd_data)
  );

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unc_weight_r   <= 13'd819;
      tall_limit_r   <= 15'd500;
      ground_clear_r <= 16'sd50;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_UNC_WEIGHT:   unc_weight_r   <= cfg_wdata[12:0];
        CFG_TALL_LIMIT:   tall_limit_r   <= cfg_wdata[14:0];
        CFG_GROUND_CLEAR: ground_clear_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // ---- blend: numerators then divide by ten ----
  logic [12:0] rd_sc;
  logic [16:0] num_cost_nxt, num_unc_nxt;
  logic [32:0] q_cost_prod, q_unc_prod;
  logic [12:0] q_cost, q_unc;
  voxel_entry_t new_entry;

  always_comb begin
    rd_sc        = class_cost(label_r);
    num_cost_nxt = 17'(rd_sc) * 17'd3 + 17'(rd_data.cost) * 17'd7 + 17'd5;
    num_unc_nxt  = 17'(obs_unc_r) * 17'd3 + 17'(rd_data.unc) * 17'd7 + 17'd5;
  end

  always_comb begin
    q_cost_prod = 33'(num_cost_r) * 33'(RECIP10);
    q_unc_prod  = 33'(num_unc_r) * 33'(RECIP10);
    q_cost      = q_cost_prod[RECIP_SHIFT+12:RECIP_SHIFT];
    q_unc       = q_unc_prod[RECIP_SHIFT+12:RECIP_SHIFT];

    new_entry = old_r;
    if (query_r) begin
      if (old_r.count == '0) begin
        new_entry.cost = HALF_Q12;
        new_entry.unc  = ONE_Q12;
        new_entry.cls  = '0;
      end
    end else begin
      new_entry.count = (old_r.count == '1) ? old_r.count : old_r.count + 16'd1;
      if (old_r.count == '0) begin
        new_entry.cost = sc_r;
        new_entry.unc  = obs_unc_r;
        new_entry.cls  = label_r;
      end else begin
        new_entry.cost = q_cost;
        new_entry.unc  = q_unc;
        // class follows the observation only if it is more certain than the average
        if (obs_unc_r < q_unc) begin
          new_entry.cls = label_r;
        end
      end
    end
  end

  // store write: sweep after reset, otherwise write-back of an observation
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = new_entry;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == S_BLEND && !query_r) begin
      ram_we = 1'b1;
    end
  end

  // ---- total cost ----
  logic [12:0] w_sat;
  logic [25:0] w_prod;
  logic [13:0] tsum_nxt;
  logic [32:0] t10_prod;
  logic [13:0] t10;
  logic        tall, low_floor;
  logic [13:0] tsel;
  logic [12:0] total_nxt;
  logic [19:0] occ_prod;

  always_comb begin
    w_sat    = (unc_weight_r > ONE_Q12) ? ONE_Q12 : unc_weight_r;
    w_prod   = 26'(w_sat) * 26'(cur_r.unc) + 26'(HALF_Q12);
    tsum_nxt = 14'(cur_r.cost) + w_prod[25:12];

    t10_prod  = 33'(tsum_r + 14'd5) * 33'(RECIP10);
    t10       = t10_prod[RECIP_SHIFT+13:RECIP_SHIFT];
    tall      = $signed({height_r[15], height_r}) > $signed({2'b00, tall_limit_r});
    low_floor = (height_r < ground_clear_r) && (cur_r.cls == FLOOR_CLASS);
    if (tall) begin
      tsel = t10;
    end else if (low_floor) begin
      tsel = '0;
    end else begin
      tsel = tsum_r;
    end
    total_nxt = (tsel > 14'(ONE_Q12)) ? ONE_Q12 : tsel[12:0];

    occ_prod = 20'(total_r) * 20'd100;
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_addr_r == '1) state_nxt = S_IDLE;
      S_IDLE:   if (in_xfer) state_nxt = S_READ;
      S_READ:   state_nxt = S_BLEND;
      S_BLEND:  state_nxt = S_WEIGHT;
      S_WEIGHT: state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_OCC;
      S_OCC:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == S_OCC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      query_r   <= in_tuser;
      addr_r    <= in_tdata[ADDR_W-1:0];
      label_r   <= in_tdata[22:15];
      obs_unc_r <= (in_tdata[35:23] > ONE_Q12) ? ONE_Q12 : in_tdata[35:23];
      height_r  <= $signed(in_tdata[51:36]);
    end
    if (state_r == S_READ) begin
      old_r      <= rd_data;
      sc_r       <= rd_sc;
      num_cost_r <= num_cost_nxt;
      num_unc_r  <= num_unc_nxt;
    end
    if (state_r == S_BLEND) begin
      cur_r <= new_entry;
    end
    if (state_r == S_WEIGHT) begin
      tsum_r <= tsum_nxt;
    end
    if (state_r == S_SCALE) begin
      total_r <= total_nxt;
    end
    if (state_r == S_OCC && out_free) begin
      out_data_r <= {2'b00, cur_r.count, cur_r.cls, cur_r.unc, cur_r.cost,
                     occ_prod[18:12], total_r};
    end
  end

endmodule
`default_nettype wire

>>> hdl/svcu_checker.sv
// Port-level checks for the semantic voxel cost block, bound to the top level.
`default_nettype none
module svcu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // cost and occupancy stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:0] <= 13'd4096) && (out_tdata[19:13] <= 7'd100))
    else $error("total cost or occupancy out of range");

  // one item in flight: no transfer in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // reset leaves the block clearing with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

endmodule

bind semantic_voxel_cost_update svcu_checker u_svcu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
